### rtl/mcsd_pkg.sv
// Shared types, constants and saturating add for the min-cost state sequence decoder.
// No dependencies.
package mcsd_pkg;

    localparam int MCSD_MAX_STATES = 8;
    localparam int MCSD_MAX_STEPS  = 1024;
    localparam int SUM_W           = 40;
    localparam int AMT_W           = 24;

    typedef enum logic [1:0] {
        CMD_COST  = 2'd0,
        CMD_LOSS  = 2'd1,
        CMD_LABEL = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic {
        KIND_DONE  = 1'b0,
        KIND_LABEL = 1'b1
    } t_kind;

    typedef struct packed {
        t_cmd        cmd;
        logic [9:0]  time_index;
        logic [2:0]  from_state;
        logic [2:0]  to_state;
        logic [23:0] amount;
        logic        last_loss;
    } t_in_item;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  label;
        logic [39:0] total_cost;
    } t_out_item;

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                                 input logic [SUM_W-1:0] b);
        logic [SUM_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[SUM_W] ? {SUM_W{1'b1}} : s[SUM_W-1:0];
    endfunction

endpackage

### rtl/mcsd_ram.sv
// Simple dual-port synchronous RAM, one write and one read port, registered read data.
// No dependencies.
module mcsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/min_cost_state_sequence_decoder_unit.sv
// Min-cost state sequence decoder: sequencer around cost, loss, value and label RAMs.
// Depends on mcsd_pkg and mcsd_ram.
// Cost and plain loss writes leave the unit idle. A label read goes through the label RAM and
// S_LABEL; out of range it answers from idle with label 0. Decode on last loss: busy while it
// copies the last loss row, recurses back to row 0 via the one value RAM read port and traces
// labels forward; the result comes as busy falls. The receiver cannot stall; the result strobe
// is one cycle. Sync active-low reset clears control, cost valid bits, length, K to 8.
module min_cost_state_sequence_decoder_unit
    import mcsd_pkg::*;
#(
    parameter int MAX_STATES = MCSD_MAX_STATES,
    parameter int MAX_STEPS  = MCSD_MAX_STEPS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_item,
    input  logic      i_cfg_we,
    input  logic [3:0] i_cfg_data,
    output logic      o_valid,
    output t_out_item o_item
);
    localparam int SW  = $clog2(MAX_STATES);
    localparam int TW  = $clog2(MAX_STEPS);
    localparam int LW  = $clog2(MAX_STEPS + 1);
    localparam int VAW = TW + SW;
    localparam int CAW = 2 * SW;

    typedef enum logic [3:0] {
        S_IDLE, S_LABEL, S_CP_RD, S_CP_WR, S_RC_RD, S_RC_ACC, S_RC_WR,
        S_A_RD, S_A_ACC, S_B_RD, S_B_ACC
    } t_state;

    t_state           r_state;
    logic             r_vld;
    t_out_item        r_out;
    logic [3:0]       r_states;
    logic [LW-1:0]    r_seq;
    logic [TW-1:0]    r_row, r_last;
    logic [SW-1:0]    r_j, r_i, r_klast, r_pick, r_prev;
    logic [SUM_W-1:0] r_m, r_total;
    logic             r_cm_hit;
    logic [(1<<CAW)-1:0] r_cvld;

    // memory ports
    logic             cm_we, cm_re, lm_we, lm_re, vm_we, vm_re, lb_we, lb_re;
    logic [CAW-1:0]   cm_wa, cm_ra;
    logic [VAW-1:0]   lm_wa, lm_ra, vm_wa, vm_ra;
    logic [TW-1:0]    lb_wa, lb_ra;
    logic [SUM_W-1:0] vm_wd, vm_rdata;
    logic [AMT_W-1:0] cm_rdata, lm_rdata;
    logic [3:0]       lb_wd, lb_rdata;

    logic             accept, from_ok, to_ok, tix_ok, in_seq;
    logic [TW-1:0]    tix;
    logic [SW-1:0]    from_s, to_s;
    logic [SUM_W-1:0] c_val, cand, m_new;
    logic             first, better;
    logic [SW-1:0]    pick_now;
    logic [3:0]       k_act;

    assign accept  = start && !busy;
    assign from_ok = 32'(i_item.from_state) < MAX_STATES;
    assign to_ok   = 32'(i_item.to_state) < MAX_STATES;
    assign tix_ok  = 32'(i_item.time_index) < MAX_STEPS;
    assign tix     = TW'(i_item.time_index);
    assign from_s  = SW'(i_item.from_state);
    assign to_s    = SW'(i_item.to_state);
    assign in_seq  = tix_ok && (32'(i_item.time_index) < 32'(r_seq));

    // register value 0 acts as 1, above the array size acts as the array size
    always_comb begin
        if (r_states == 4'd0) begin
            k_act = 4'd1;
        end else if (32'(r_states) > MAX_STATES) begin
            k_act = 4'(MAX_STATES);
        end else begin
            k_act = r_states;
        end
    end

    // cost entries never written read as zero
    assign c_val = r_cm_hit ? SUM_W'(cm_rdata) : '0;
    assign cand  = (r_state == S_A_ACC) ? vm_rdata : sat_add(vm_rdata, c_val);
    assign first = (r_state == S_RC_ACC) ? (r_i == '0) : (r_j == '0);
    // strict less-than keeps the lowest index on ties
    assign better   = first || (cand < r_m);
    assign m_new    = better ? cand : r_m;
    assign pick_now = better ? r_j : r_pick;

    always_comb begin
        cm_we = 1'b0; cm_wa = {from_s, to_s};
        cm_re = 1'b0; cm_ra = {r_i, r_j};
        lm_we = 1'b0; lm_wa = {tix, to_s};
        lm_re = 1'b0; lm_ra = {r_row, r_j};
        vm_we = 1'b0; vm_wa = {r_row, r_j}; vm_wd = SUM_W'(lm_rdata);
        vm_re = 1'b0; vm_ra = {r_row, r_j};
        lb_we = 1'b0; lb_wa = r_row; lb_wd = 4'(pick_now) + 4'd1;
        lb_re = 1'b0; lb_ra = tix;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    cm_we = (i_item.cmd == CMD_COST) && from_ok && to_ok;
                    lm_we = (i_item.cmd == CMD_LOSS) && tix_ok && to_ok;
                    lb_re = (i_item.cmd == CMD_LABEL) && in_seq;
                end
            end
            S_CP_RD: lm_re = 1'b1;
            S_CP_WR: vm_we = 1'b1;
            S_RC_RD: begin
                vm_re = 1'b1;
                vm_ra = {TW'(r_row + 1'b1), r_i};
                cm_re = 1'b1;
                lm_re = 1'b1;
            end
            S_RC_WR: begin
                vm_we = 1'b1;
                vm_wd = sat_add(SUM_W'(lm_rdata), r_m);
            end
            S_A_RD: vm_re = 1'b1;
            S_A_ACC: lb_we = (r_j == r_klast);
            S_B_RD: begin
                vm_re = 1'b1;
                cm_re = 1'b1;
                cm_ra = {r_prev, r_j};
            end
            S_B_ACC: lb_we = (r_j == r_klast);
            default: ;
        endcase
    end

    mcsd_ram #(.WIDTH(AMT_W), .DEPTH(1 << CAW)) u_cost (
        .i_clk(i_clk), .i_we(cm_we), .i_waddr(cm_wa), .i_wdata(i_item.amount),
        .i_re(cm_re), .i_raddr(cm_ra), .o_rdata(cm_rdata)
    );
    mcsd_ram #(.WIDTH(AMT_W), .DEPTH(1 << VAW)) u_loss (
        .i_clk(i_clk), .i_we(lm_we), .i_waddr(lm_wa), .i_wdata(i_item.amount),
        .i_re(lm_re), .i_raddr(lm_ra), .o_rdata(lm_rdata)
    );
    mcsd_ram #(.WIDTH(SUM_W), .DEPTH(1 << VAW)) u_value (
        .i_clk(i_clk), .i_we(vm_we), .i_waddr(vm_wa), .i_wdata(vm_wd),
        .i_re(vm_re), .i_raddr(vm_ra), .o_rdata(vm_rdata)
    );
    mcsd_ram #(.WIDTH(4), .DEPTH(1 << TW)) u_label (
        .i_clk(i_clk), .i_we(lb_we), .i_waddr(lb_wa), .i_wdata(lb_wd),
        .i_re(lb_re), .i_raddr(lb_ra), .o_rdata(lb_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_vld    <= 1'b0;
            r_states <= 4'd8;
            r_seq    <= '0;
            r_cvld   <= '0;
        end else begin
            r_vld <= 1'b0;
            if (i_cfg_we) begin
                r_states <= i_cfg_data;
            end
            if (cm_we) begin
                r_cvld[cm_wa] <= 1'b1;
            end
            if (cm_re) begin
                r_cm_hit <= r_cvld[cm_ra];
            end
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        case (i_item.cmd)
                            CMD_LOSS: begin
                                if (tix_ok && i_item.last_loss) begin
                                    r_seq    <= LW'(i_item.time_index) + 1'b1;
                                    r_row    <= tix;
                                    r_last   <= tix;
                                    r_klast  <= SW'(k_act - 4'd1);
                                    r_j      <= '0;
                                    r_state  <= S_CP_RD;
                                end
                            end
                            CMD_LABEL: begin
                                if (in_seq) begin
                                    r_state <= S_LABEL;
                                end else begin
                                    r_vld <= 1'b1;
                                    r_out <= '{kind: KIND_LABEL, label: 4'd0, total_cost: '0};
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_LABEL: begin
                    r_vld   <= 1'b1;
                    r_out   <= '{kind: KIND_LABEL, label: lb_rdata, total_cost: '0};
                    r_state <= S_IDLE;
                end
                S_CP_RD: r_state <= S_CP_WR;
                S_CP_WR: begin
                    if (r_j == r_klast) begin
                        r_j <= '0;
                        r_i <= '0;
                        if (r_row == '0) begin
                            r_state <= S_A_RD;
                        end else begin
                            r_row   <= r_row - 1'b1;
                            r_state <= S_RC_RD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_CP_RD;
                    end
                end
                S_RC_RD: r_state <= S_RC_ACC;
                S_RC_ACC: begin
                    r_m <= m_new;
                    if (r_i == r_klast) begin
                        r_state <= S_RC_WR;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_RC_RD;
                    end
                end
                S_RC_WR: begin
                    r_i <= '0;
                    if (r_j == r_klast) begin
                        r_j <= '0;
                        if (r_row == '0) begin
                            r_state <= S_A_RD;
                        end else begin
                            r_row   <= r_row - 1'b1;
                            r_state <= S_RC_RD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= S_RC_RD;
                    end
                end
                S_A_RD, S_B_RD: begin
                    r_state <= (r_state == S_A_RD) ? S_A_ACC : S_B_ACC;
                end
                S_A_ACC, S_B_ACC: begin
                    r_m    <= m_new;
                    r_pick <= pick_now;
                    if (r_j == r_klast) begin
                        r_prev <= pick_now;
                        r_j    <= '0;
                        if (r_state == S_A_ACC) begin
                            r_total <= m_new;
                        end
                        if (r_row == r_last) begin
                            r_vld   <= 1'b1;
                            r_out   <= '{kind: KIND_DONE, label: 4'd0,
                                         total_cost: (r_state == S_A_ACC) ? m_new : r_total};
                            r_state <= S_IDLE;
                        end else begin
                            r_row   <= r_row + 1'b1;
                            r_state <= S_B_RD;
                        end
                    end else begin
                        r_j     <= r_j + 1'b1;
                        r_state <= (r_state == S_A_ACC) ? S_A_RD : S_B_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy    = (r_state != S_IDLE);
    assign o_valid = r_vld;
    assign o_item  = r_out;

    // a decode or label read always ends with a result
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid) else $error("busy dropped without a result");
    a_done_no_label: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind == KIND_DONE) |-> (o_item.label == 4'd0))
        else $error("decode result carries a label");
    a_label_no_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.kind == KIND_LABEL) |-> (o_item.total_cost == '0))
        else $error("label result carries a cost");
endmodule
